// File: rtl/core/mhc_pkg.sv
// mhc_pkg: shared widths, register indexes and the blocker-count rule
// for the magic hash collision check; no dependencies
package mhc_pkg;

  localparam int MAGIC_W    = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int PAT_W      = 13;   // pattern counter, holds up to 2^12
  localparam int RULE_W     = 4;    // blocker count, at most 12
  localparam int EPOCH_W    = 8;    // seen-table tag width

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIECE_KIND   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_INDEX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OCC_MASK     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_SHIFT  = 2'd3;

  localparam logic       PIECE_ROOK        = 1'b0;
  localparam logic [5:0] INDEX_SHIFT_RESET = 6'd52;

  localparam logic [RULE_W-1:0] ROOK_BASE   = 4'd10;
  localparam logic [RULE_W-1:0] BISHOP_BASE = 4'd5;
  localparam logic [2:0] EDGE_LO  = 3'd0;
  localparam logic [2:0] EDGE_HI  = 3'd7;
  localparam logic [2:0] RING_LO  = 3'd2;
  localparam logic [2:0] RING_HI  = 3'd5;
  localparam logic [2:0] CORE_LO  = 3'd3;
  localparam logic [2:0] CORE_HI  = 3'd4;
  localparam logic [5:0] SQ_A1    = 6'd0;
  localparam logic [5:0] SQ_H1    = 6'd7;
  localparam logic [5:0] SQ_A8    = 6'd56;
  localparam logic [5:0] SQ_H8    = 6'd63;

  // number of relevant blocker bits for a square
  function automatic logic [RULE_W-1:0] rule_bits(input logic piece, input logic [5:0] sq);
    logic [2:0] file;
    logic [2:0] rank;
    logic [RULE_W-1:0] n;
    file = sq[2:0];
    rank = sq[5:3];
    if (piece == PIECE_ROOK) begin
      n = ROOK_BASE;
      if (file == EDGE_LO || file == EDGE_HI) n = n + 4'd1;
      if (rank == EDGE_LO || rank == EDGE_HI) n = n + 4'd1;
    end else begin
      n = BISHOP_BASE;
      if (file >= RING_LO && file <= RING_HI && rank >= RING_LO && rank <= RING_HI)
        n = n + 4'd2;
      if (file >= CORE_LO && file <= CORE_HI && rank >= CORE_LO && rank <= CORE_HI)
        n = n + 4'd2;
      if (sq == SQ_A1 || sq == SQ_H1 || sq == SQ_A8 || sq == SQ_H8)
        n = n + 4'd1;
    end
    return n;
  endfunction

  // index of the lowest set bit, the bit that flips in a gray code step
  function automatic logic [RULE_W-1:0] low_bit(input logic [PAT_W-1:0] v);
    logic [RULE_W-1:0] j;
    j = '0;
    for (int i = PAT_W - 1; i >= 0; i--) begin
      if (v[i]) j = RULE_W'(i);
    end
    return j;
  endfunction

endpackage

// File: rtl/core/mhc_cand_if.sv
// mhc_cand_if: candidate channel, valid/ready with the magic word
// depends on mhc_pkg
interface mhc_cand_if;
  import mhc_pkg::*;

  logic               valid;
  logic               ready;
  logic [MAGIC_W-1:0] candidate_magic;

  modport source (output valid, output candidate_magic, input ready);
  modport sink (input valid, input candidate_magic, output ready);
endinterface

// File: rtl/core/mhc_result_if.sv
// mhc_result_if: result channel, valid/ready with the verdict bit
// no dependencies
interface mhc_result_if;
  logic valid;
  logic ready;
  logic is_valid;

  modport source (output valid, output is_valid, input ready);
  modport sink (input valid, input is_valid, output ready);
endinterface

// File: rtl/core/mhc_seen_ram.sv
// mhc_seen_ram: single write port, single read port tag memory
// with registered read data; no dependencies
module mhc_seen_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/magic_hash_collision_check_top.sv
// channel | dir | word                      | accepted when
// cand    | in  | candidate_magic (64 bit)  | cand.valid & cand.ready
// result  | out | is_valid (1 bit)          | result.valid & result.ready
// cfg     | in  | cfg_index, cfg_data       | cfg_we
//
// one candidate runs a scan of all 64 mask bits, then one seen-table probe per blocker pattern
// (2^n patterns, n the blocker count of the square, 5..12), then the probe pipe drains;
// a repeated index ends the walk early
// the seen table is cleared one entry a cycle (all 2^MAX_INDEX_BITS entries) after reset and
// after every 255th candidate; no candidate is taken meanwhile
// a finished verdict waits in the output register; a new candidate is taken while it waits
// depends on mhc_pkg, mhc_cand_if, mhc_result_if, mhc_seen_ram
module magic_hash_collision_check_top #(
  parameter int MAX_INDEX_BITS = 12,
  parameter int MAX_MASK_BITS  = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  mhc_cand_if.sink                       cand,
  mhc_result_if.source                   result,
  input  logic                           cfg_we,
  input  logic [mhc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mhc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mhc_pkg::*;

  localparam int TI_W = (MAX_MASK_BITS > 1) ? $clog2(MAX_MASK_BITS) : 1;
  localparam int NP_W = $clog2(MAX_MASK_BITS + 1);
  localparam logic [5:0] SHIFT_FLOOR = 6'(64 - MAX_INDEX_BITS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // configuration
  logic        piece_kind;
  logic [5:0]  square_index;
  logic [63:0] occ_mask;
  logic [5:0]  index_shift;

  logic [2:0]  state;

  // setup scan
  logic [63:0] magic_sh;
  logic [63:0] mask_sh;
  logic [5:0]  scan_cnt;
  logic [NP_W-1:0] npos;
  logic [63:0] terms [MAX_MASK_BITS];

  // pattern walk
  logic [5:0]       shift_eff;
  logic [PAT_W-1:0] count_last;
  logic [PAT_W-1:0] k;
  logic [63:0]      prod;

  // probe stage
  logic                      s2_valid;
  logic                      s2_last;
  logic                      s2_fwd;
  logic [MAX_INDEX_BITS-1:0] s2_idx;

  logic [EPOCH_W-1:0]        epoch;
  logic [MAX_INDEX_BITS-1:0] clr_addr;
  logic                      cand_ok;
  logic                      res_valid;
  logic                      res_bit;

  logic                      cand_fire;
  logic [RULE_W-1:0]         n_bits;
  logic [PAT_W-1:0]          kp1;
  logic [PAT_W-1:0]          kp1_sh;
  logic [RULE_W-1:0]         flip_bit;
  logic [63:0]               term;
  logic [63:0]               prod_next;
  logic [63:0]               prod_shr;
  logic [MAX_INDEX_BITS-1:0] idx_now;
  logic                      hit;

  logic                      mem_wr_en;
  logic [MAX_INDEX_BITS-1:0] mem_wr_addr;
  logic [EPOCH_W-1:0]        mem_wr_data;
  logic                      mem_rd_en;
  logic [EPOCH_W-1:0]        mem_rd_data;

  assign cand.ready      = (state == ST_IDLE);
  assign cand_fire       = cand.valid && cand.ready;
  assign result.valid    = res_valid;
  assign result.is_valid = res_bit;

  assign n_bits = rule_bits(piece_kind, square_index);

  // gray code walk: each step adds or removes one shifted copy of the magic
  assign kp1      = k + PAT_W'(1);
  assign flip_bit = low_bit(kp1);
  assign kp1_sh   = kp1 >> flip_bit;
  assign term     = (flip_bit < MAX_MASK_BITS) ? terms[flip_bit[TI_W-1:0]] : '0;
  assign prod_next = kp1_sh[1] ? (prod - term) : (prod + term);

  assign prod_shr = prod >> shift_eff;
  assign idx_now  = prod_shr[MAX_INDEX_BITS-1:0];

  // same-entry write in the previous cycle is caught by s2_fwd
  assign hit = (mem_rd_data == epoch) || s2_fwd;

  assign mem_rd_en   = (state == ST_WALK);
  assign mem_wr_en   = (state == ST_CLEAR) || s2_valid;
  assign mem_wr_addr = (state == ST_CLEAR) ? clr_addr : s2_idx;
  assign mem_wr_data = (state == ST_CLEAR) ? '0 : epoch;

  mhc_seen_ram #(
    .ADDR_W (MAX_INDEX_BITS),
    .DATA_W (EPOCH_W)
  ) u_seen_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (idx_now),
    .rd_data (mem_rd_data)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      piece_kind   <= 1'b0;
      square_index <= '0;
      occ_mask     <= '0;
      index_shift  <= INDEX_SHIFT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIECE_KIND:   piece_kind   <= cfg_data[0];
        CFG_SQUARE_INDEX: square_index <= cfg_data[5:0];
        CFG_OCC_MASK:     occ_mask     <= cfg_data;
        CFG_INDEX_SHIFT:  index_shift  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (cand_fire) begin
          magic_sh   <= cand.candidate_magic;
          mask_sh    <= occ_mask;
          npos       <= '0;
          prod       <= '0;
          k          <= '0;
          shift_eff  <= (index_shift < SHIFT_FLOOR) ? SHIFT_FLOOR : index_shift;
          count_last <= (PAT_W'(1) << n_bits) - PAT_W'(1);
          for (int i = 0; i < MAX_MASK_BITS; i++) begin
            terms[i] <= '0;
          end
        end
      end
      ST_SETUP: begin
        // the j-th set mask bit at position p gives term magic << p
        if (mask_sh[0] && (npos < MAX_MASK_BITS)) begin
          terms[npos[TI_W-1:0]] <= magic_sh;
          npos <= npos + NP_W'(1);
        end
        mask_sh  <= mask_sh >> 1;
        magic_sh <= magic_sh << 1;
      end
      ST_WALK: begin
        s2_idx  <= idx_now;
        s2_last <= (k == count_last);
        s2_fwd  <= s2_valid && (s2_idx == idx_now);
        prod    <= prod_next;
        k       <= kp1;
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      epoch     <= '0;
      scan_cnt  <= '0;
      s2_valid  <= 1'b0;
      cand_ok   <= 1'b0;
      res_valid <= 1'b0;
      res_bit   <= 1'b0;
    end else begin
      if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + MAX_INDEX_BITS'(1);
          if (clr_addr == {MAX_INDEX_BITS{1'b1}}) begin
            epoch <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cand_fire) begin
            epoch    <= epoch + EPOCH_W'(1);
            scan_cnt <= '0;
            state    <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          scan_cnt <= scan_cnt + 6'd1;
          if (scan_cnt == 6'd63) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          s2_valid <= 1'b1;
          if (k == count_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          s2_valid <= 1'b0;
        end
        ST_DONE: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            res_bit   <= cand_ok;
            clr_addr  <= '0;
            state     <= (epoch == {EPOCH_W{1'b1}}) ? ST_CLEAR : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // probe result ends the walk on a repeat or after the last pattern
      if (s2_valid && (state == ST_WALK || state == ST_DRAIN)) begin
        if (hit) begin
          cand_ok  <= 1'b0;
          s2_valid <= 1'b0;
          state    <= ST_DONE;
        end else if (s2_last) begin
          cand_ok  <= 1'b1;
          s2_valid <= 1'b0;
          state    <= ST_DONE;
        end
      end
    end
  end

endmodule

// File: rtl/core/mhc_checker.sv
// mhc_checker: port-level checks of the magic hash collision check,
// bound to magic_hash_collision_check_top; no dependencies
module mhc_checker (
  input logic clk,
  input logic rst,
  input logic cand_valid,
  input logic cand_ready,
  input logic res_valid,
  input logic res_ready,
  input logic res_is_valid
);

  logic [1:0] pend;
  logic       cand_fire;
  logic       res_fire;

  assign cand_fire = cand_valid && cand_ready;
  assign res_fire  = res_valid && res_ready;

  // candidates taken whose verdict is not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 2'(cand_fire) - 2'(res_fire);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result word present after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cand_fire |=> !cand_ready)
    else $error("candidate port ready right after taking a word");

  a_no_quick_verdict: assert property (@(posedge clk) disable iff (rst)
    cand_fire |=> ##1 !$rose(res_valid))
    else $error("verdict appeared before the mask scan could finish");

  a_verdict_has_cause: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (pend != 2'd0))
    else $error("result word without a pending candidate");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_is_valid)))
    else $error("stalled result word changed");

endmodule

bind magic_hash_collision_check_top mhc_checker u_mhc_checker (
  .clk          (clk),
  .rst          (rst),
  .cand_valid   (cand.valid),
  .cand_ready   (cand.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_is_valid (result.is_valid)
);

// File: sim/tb_top.sv
// tb_top: self-checking bench for magic_hash_collision_check_top, predicts each verdict
// by walking every blocker pattern of the configured mask and probing for index reuse
// depends on mhc_pkg, mhc_cand_if, mhc_result_if and the block under test
`timescale 1ns / 100ps

module tb_top;
  import mhc_pkg::*;

  localparam int INDEX_BITS    = 12;
  localparam int MASK_BITS     = 12;
  localparam int SHIFT_FLOOR   = 64 - INDEX_BITS;
  localparam int ITEM_TARGET   = 140;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 40000;
  localparam logic PIECE_BISHOP = 1'b1;

  typedef struct {
    logic [MAGIC_W-1:0] magic;
    logic               verdict;
  } verdict_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mhc_cand_if   cand_ch ();
  mhc_result_if result_ch ();

  magic_hash_collision_check_top #(
    .MAX_INDEX_BITS(INDEX_BITS),
    .MAX_MASK_BITS (MASK_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cand     (cand_ch),
    .result   (result_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // shadow copy of the configuration registers
  logic       mdl_piece  = PIECE_ROOK;
  logic [5:0] mdl_square = '0;
  logic [63:0] mdl_mask  = '0;
  logic [5:0] mdl_shift  = INDEX_SHIFT_RESET;

  logic [MAGIC_W-1:0] magic_q[$];
  verdict_t           verdict_q[$];

  bit no_idle;
  int send_gap;
  int ready_hold;
  int quiet_cycles;
  int issued;
  int accepted;
  int settings_used;
  int n_valid;
  int n_invalid;
  int err_count;

  function automatic int blocker_count(input logic piece, input logic [5:0] sq);
    int f;
    int r;
    int n;
    f = sq % 8;
    r = sq / 8;
    if (piece == PIECE_ROOK) begin
      n = 10;
      if (f == 0 || f == 7) n++;
      if (r == 0 || r == 7) n++;
    end else begin
      n = 5;
      if (f >= 2 && f <= 5 && r >= 2 && r <= 5) n += 2;
      if (f >= 3 && f <= 4 && r >= 3 && r <= 4) n += 2;
      if (sq == SQ_A1 || sq == SQ_H1 || sq == SQ_A8 || sq == SQ_H8) n++;
    end
    return n;
  endfunction

  // shifts below the table width saturate so the index fits the seen table
  function automatic int active_shift();
    return (mdl_shift < SHIFT_FLOOR) ? SHIFT_FLOOR : int'(mdl_shift);
  endfunction

  // 1 when no two blocker boards of the current setting land on one index
  function automatic logic collision_free(input logic [MAGIC_W-1:0] magic);
    bit          seen [0:(1<<INDEX_BITS)-1];
    int          slot [0:MASK_BITS-1];
    int          nslot;
    int          nbits;
    int          sh;
    logic [63:0] board;
    logic [63:0] product;
    logic [INDEX_BITS-1:0] idx;
    seen  = '{default: 1'b0};
    nbits = blocker_count(mdl_piece, mdl_square);
    sh    = active_shift();
    nslot = 0;
    for (int b = 0; b < 64 && nslot < MASK_BITS; b++) begin
      if (mdl_mask[b]) begin
        slot[nslot] = b;
        nslot++;
      end
    end
    for (int p = 0; p < (1 << nbits); p++) begin
      board = '0;
      for (int j = 0; j < nslot && j < nbits; j++) begin
        if (p[j]) board[slot[j]] = 1'b1;
      end
      product = board * magic;
      idx     = INDEX_BITS'(product >> sh);
      if (seen[idx]) return 1'b0;
      seen[idx] = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // magic that lifts a contiguous mask starting at offset straight into the index bits;
  // extra bits high enough to fall off the top of every product are random
  function automatic logic [63:0] clean_magic(input int offset);
    int sh;
    logic [63:0] keep_high;
    sh = active_shift();
    if (offset > sh) return rand64();
    keep_high = ~((64'd1 << (64 - offset)) - 64'd1);
    return (64'd1 << (sh - offset)) | (rand64() & keep_high);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_PIECE_KIND:   mdl_piece  = data[0];
      CFG_SQUARE_INDEX: mdl_square = data[5:0];
      CFG_OCC_MASK:     mdl_mask   = data;
      CFG_INDEX_SHIFT:  mdl_shift  = data[5:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (magic_q.size() != 0 || cand_ch.valid || verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender holds off until every verdict is back, then the block is reprogrammed
  task automatic apply_setting(input logic piece, input logic [5:0] sq,
                               input logic [63:0] mask, input logic [5:0] shift);
    wait_idle();
    write_reg(CFG_PIECE_KIND, CFG_DATA_W'(piece));
    write_reg(CFG_SQUARE_INDEX, CFG_DATA_W'(sq));
    write_reg(CFG_OCC_MASK, mask);
    write_reg(CFG_INDEX_SHIFT, CFG_DATA_W'(shift));
    settings_used++;
    @(negedge clk);
  endtask

  task automatic queue_magic(input logic [MAGIC_W-1:0] m);
    magic_q.push_back(m);
    issued++;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst                      = 1'b1;
    cfg_we                   = 1'b0;
    cfg_index                = '0;
    cfg_data                 = '0;
    cand_ch.valid            = 1'b0;
    cand_ch.candidate_magic  = '0;
    result_ch.ready          = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // candidate driver
  always @(posedge clk) begin
    verdict_t entry;
    if (rst) begin
      cand_ch.valid <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (cand_ch.valid && cand_ch.ready) begin
        entry.magic   = cand_ch.candidate_magic;
        entry.verdict = collision_free(cand_ch.candidate_magic);
        verdict_q.push_back(entry);
        accepted++;
      end
      if (cand_ch.valid && !cand_ch.ready) begin
        // word stays on the bus until taken
      end else if (send_gap != 0) begin
        cand_ch.valid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (magic_q.size() != 0) begin
        cand_ch.valid           <= 1'b1;
        cand_ch.candidate_magic <= magic_q.pop_front();
        send_gap                <= pick_gap();
      end else begin
        cand_ch.valid <= 1'b0;
      end
    end
  end

  // verdict monitor
  always @(posedge clk) begin
    verdict_t entry;
    int hold;
    if (rst) begin
      result_ch.ready <= 1'b0;
      ready_hold      <= 0;
    end else begin
      hold = ready_hold;
      if (result_ch.valid && result_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: verdict word with nothing pending, got %0b", $time, result_ch.is_valid);
          err_count++;
        end else begin
          entry = verdict_q.pop_front();
          if (result_ch.is_valid !== entry.verdict) begin
            $display("%0t: is_valid mismatch for magic %h: expected %0b, got %0b",
                     $time, entry.magic, entry.verdict, result_ch.is_valid);
            err_count++;
          end else if (entry.verdict) begin
            n_valid++;
          end else begin
            n_invalid++;
          end
        end
        hold = pick_gap();
      end
      if (hold != 0) begin
        result_ch.ready <= 1'b0;
        ready_hold      <= hold - 1;
      end else begin
        result_ch.ready <= 1'b1;
        ready_hold      <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cand_ch.valid && cand_ch.ready) || (result_ch.valid && result_ch.ready) || cfg_we)
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d verdicts outstanding",
               $time, quiet_cycles, verdict_q.size());
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic        piece;
    logic [5:0]  sq;
    logic [5:0]  shift;
    logic [63:0] mask;
    logic [63:0] m;
    int          nb;
    int          pick;
    int          run;
    int          offset;

    @(negedge clk);
    while (rst) @(negedge clk);

    // reset setting: empty mask, every board is zero
    queue_magic('0);
    queue_magic('1);

    // rook, inner square, mask run at bit 8, ten index bits
    apply_setting(PIECE_ROOK, 6'd27, 64'h3FF << 8, 6'd54);
    queue_magic(clean_magic(8));
    queue_magic(64'h8000_0000_0000_0000);
    queue_magic(64'd1);

    // rook, top corner, mask in the top twelve bits
    apply_setting(PIECE_ROOK, 6'd63, 64'hFFF << 52, 6'd52);
    queue_magic(clean_magic(52));
    queue_magic('1);
    queue_magic('0);

    // bishop corner, mask with fewer bits than blockers
    apply_setting(PIECE_BISHOP, 6'd7, 64'h8000_0000_0100_0010, 6'd58);
    queue_magic(rand64());
    queue_magic(clean_magic(4));

    // bishop center, full mask, shift below the table width
    apply_setting(PIECE_BISHOP, 6'd36, '1, 6'd0);
    queue_magic(clean_magic(0));
    queue_magic(rand64());

    // bishop ring square, mask wider than the pattern limit, one-bit index
    apply_setting(PIECE_BISHOP, 6'd18, 64'h00FF_FF00_0000_0000, 6'd63);
    queue_magic(clean_magic(40));
    queue_magic(rand64());

    // bishop edge, exactly as many index bits as blockers
    apply_setting(PIECE_BISHOP, 6'd1, 64'h1F << 1, 6'd59);
    queue_magic(clean_magic(1));
    queue_magic(rand64());

    // random settings, mostly contiguous masks with matching magics
    while (issued < ITEM_TARGET) begin
      piece = ($urandom_range(0, 9) < 3) ? PIECE_ROOK : PIECE_BISHOP;
      sq    = 6'($urandom_range(0, 63));
      nb    = blocker_count(piece, sq);
      pick  = $urandom_range(0, 9);
      if (pick < 6) shift = 6'($urandom_range(52, 64 - nb));
      else if (pick < 8) shift = 6'($urandom_range(52, 63));
      else if (pick < 9) shift = 6'($urandom_range(0, 51));
      else shift = ($urandom_range(0, 1) != 0) ? 6'd63 : 6'd0;
      pick   = $urandom_range(0, 9);
      offset = 0;
      if (pick < 7) begin
        run    = $urandom_range(nb, 16);
        offset = $urandom_range(1, 64 - run);
        mask   = ((64'd1 << run) - 64'd1) << offset;
      end else if (pick < 8) begin
        mask = rand64();
      end else if (pick < 9) begin
        mask = '0;
        repeat ($urandom_range(0, nb - 1)) mask[$urandom_range(0, 63)] = 1'b1;
      end else begin
        mask = '1;
      end
      no_idle = ($urandom_range(0, 3) == 0);
      apply_setting(piece, sq, mask, shift);
      repeat ($urandom_range(5, 12)) begin
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
          m = clean_magic(offset);
        end else if (pick < 16) begin
          m = rand64();
        end else begin
          m = clean_magic(offset);
          m[$urandom_range(0, 63)] ^= 1'b1;
        end
        queue_magic(m);
      end
    end

    wait_idle();
    $display("covered %0d candidates over %0d register settings plus the reset one",
             accepted, settings_used);
    $display("verdicts: %0d collision free, %0d colliding, %0d errors",
             n_valid, n_invalid, err_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: magic_hash_collision_check_top.f
rtl/core/mhc_pkg.sv
rtl/core/mhc_cand_if.sv
rtl/core/mhc_result_if.sv
rtl/core/mhc_seen_ram.sv
rtl/core/magic_hash_collision_check_top.sv
rtl/core/mhc_checker.sv
sim/tb_top.sv
